@@ sv/ltsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Link timeout and stall monitor package
// Shared counts, codes, payload types and the decoded command that passes
// from the classifier to the executor.
// ----------------------------------------------------------------------------
package ltsm_pkg;

	localparam int MOTOR_COUNT  = 2;
	localparam int DEVICE_COUNT = 4;
	localparam int CH_COUNT     = MOTOR_COUNT + DEVICE_COUNT;

	localparam int TIME_W   = 32;
	localparam int LEVEL_W  = 15;
	localparam int KIND_W   = 3;
	localparam int CHAN_W   = 4;
	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = SAMPLE_W + 1;
	localparam int OFF_W    = 6;
	localparam int STALL_W  = 2;
	localparam int CFG_IDX_W = 3;

	localparam int CH_IDX_W   = $clog2(CH_COUNT);
	localparam int MOT_IDX_W  = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam int OFF_SPAN   = (CH_COUNT > OFF_W) ? CH_COUNT : OFF_W;
	localparam int STALL_SPAN = (MOTOR_COUNT > STALL_W) ? MOTOR_COUNT : STALL_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [KIND_W-1:0] KIND_TICK         = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MOTOR_HEARD  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DEVICE_HEARD = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MOTOR_SAMPLE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CHECK        = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_TIMEOUT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_TIMEOUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_SPEED    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_DRIVE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIME     = 3'd4;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TICK,
		OP_MOTOR_HEARD,
		OP_DEVICE_HEARD,
		OP_SAMPLE,
		OP_CHECK
	} op_t;

	typedef struct packed {
		logic [KIND_W-1:0]          kind;
		logic [CHAN_W-1:0]          channel;
		logic signed [SAMPLE_W-1:0] motor_speed;
		logic signed [SAMPLE_W-1:0] drive_output;
	} in_item_t;

	typedef struct packed {
		logic [OFF_W-1:0]   offline_flags;
		logic [STALL_W-1:0] stall_flags;
		logic               any_stall;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]  motor_timeout;
		logic [TIME_W-1:0]  device_timeout;
		logic [LEVEL_W-1:0] stall_speed;
		logic [LEVEL_W-1:0] stall_drive;
		logic [TIME_W-1:0]  stall_time;
	} cfg_t;

	typedef struct packed {
		op_t                 op;
		logic [CH_IDX_W-1:0] idx;
		logic                cond;
	} cmd_t;

endpackage

@@ sv/link_timeout_and_stall_monitor.sv @@
// ----------------------------------------------------------------------------
// Link timeout and stall monitor
// Tracks contact times of motors and devices against per-class timeouts and
// flags motors that hold low speed under high drive for too long.
// ----------------------------------------------------------------------------
// Channel  Signals                              Direction  Moves
// item     item_valid, item_stall, item         in         one input item
// result   result_valid, result_stall, result   out        one flag report
// cfg      cfg_valid, cfg_ready, cfg_index,     in         one register write
//          cfg_data
//
// Every item gives one result. A check is taken by the executor and then walks
// all six contact stamps, one per cycle, the last only while the output register
// is free; no item is taken from the queue until the walk ends.
// A two-entry command queue lets items enter while the executor is busy.
// Reset clears time, stamps, timers and flags and loads the register defaults.
// A stalled result holds in the output register and the executor waits.
// ----------------------------------------------------------------------------
module link_timeout_and_stall_monitor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  ltsm_pkg::in_item_t                  item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output ltsm_pkg::out_item_t                 result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ltsm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ltsm_pkg::TIME_W-1:0]         cfg_data
);

	ltsm_pkg::cfg_t cfg_q;
	ltsm_pkg::cmd_t front_cmd;
	ltsm_pkg::cmd_t q_cmd;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motor_timeout  <= ltsm_pkg::TIME_W'(5000);
			cfg_q.device_timeout <= ltsm_pkg::TIME_W'(5000);
			cfg_q.stall_speed    <= ltsm_pkg::LEVEL_W'(5);
			cfg_q.stall_drive    <= ltsm_pkg::LEVEL_W'(2500);
			cfg_q.stall_time     <= ltsm_pkg::TIME_W'(20000);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ltsm_pkg::CFG_MOTOR_TIMEOUT: begin
					cfg_q.motor_timeout <= cfg_data;
				end
				ltsm_pkg::CFG_DEVICE_TIMEOUT: begin
					cfg_q.device_timeout <= cfg_data;
				end
				ltsm_pkg::CFG_STALL_SPEED: begin
					cfg_q.stall_speed <= cfg_data[ltsm_pkg::LEVEL_W-1:0];
				end
				ltsm_pkg::CFG_STALL_DRIVE: begin
					cfg_q.stall_drive <= cfg_data[ltsm_pkg::LEVEL_W-1:0];
				end
				ltsm_pkg::CFG_STALL_TIME: begin
					cfg_q.stall_time <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	ltsm_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg        (cfg_q),
		.queue_full (q_full),
		.push       (push),
		.cmd        (front_cmd)
	);

	ltsm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (front_cmd),
		.full   (q_full),
		.pop    (pop),
		.rd_cmd (q_cmd),
		.empty  (q_empty)
	);

	ltsm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_cmd        (q_cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ sv/ltsm_front.sv @@
// ----------------------------------------------------------------------------
// Link timeout and stall monitor, front end
// Accepts items, turns items with out-of-range channels into no-op commands,
// maps channels to slots and evaluates the stall condition of motor samples.
// ----------------------------------------------------------------------------
module ltsm_front (
	input  logic              item_valid,
	output logic              item_stall,
	input  ltsm_pkg::in_item_t item,
	input  ltsm_pkg::cfg_t    cfg,
	input  logic              queue_full,
	output logic              push,
	output ltsm_pkg::cmd_t    cmd
);

	logic [ltsm_pkg::MAG_W-1:0] speed_mag;
	logic [ltsm_pkg::MAG_W-1:0] drive_mag;
	logic [ltsm_pkg::MAG_W-1:0] speed_ext;
	logic [ltsm_pkg::MAG_W-1:0] drive_ext;
	logic                       motor_ok;
	logic                       device_ok;

	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full;

	assign speed_ext = {item.motor_speed[ltsm_pkg::SAMPLE_W-1], item.motor_speed};
	assign drive_ext = {item.drive_output[ltsm_pkg::SAMPLE_W-1], item.drive_output};
	assign speed_mag = item.motor_speed[ltsm_pkg::SAMPLE_W-1] ?
		(ltsm_pkg::MAG_W'(0) - speed_ext) : speed_ext;
	assign drive_mag = item.drive_output[ltsm_pkg::SAMPLE_W-1] ?
		(ltsm_pkg::MAG_W'(0) - drive_ext) : drive_ext;

	assign motor_ok  = item.channel < ltsm_pkg::CHAN_W'(ltsm_pkg::MOTOR_COUNT);
	assign device_ok = item.channel < ltsm_pkg::CHAN_W'(ltsm_pkg::DEVICE_COUNT);

	always_comb begin
		cmd.op   = ltsm_pkg::OP_NONE;
		cmd.idx  = ltsm_pkg::CH_IDX_W'(item.channel);
		cmd.cond = (speed_mag < ltsm_pkg::MAG_W'(cfg.stall_speed)) &&
			(drive_mag > ltsm_pkg::MAG_W'(cfg.stall_drive));
		case (item.kind)
			ltsm_pkg::KIND_TICK: begin
				cmd.op = ltsm_pkg::OP_TICK;
			end
			ltsm_pkg::KIND_MOTOR_HEARD: begin
				if (motor_ok) begin
					cmd.op = ltsm_pkg::OP_MOTOR_HEARD;
				end
			end
			ltsm_pkg::KIND_DEVICE_HEARD: begin
				if (device_ok) begin
					cmd.op  = ltsm_pkg::OP_DEVICE_HEARD;
					cmd.idx = ltsm_pkg::CH_IDX_W'((ltsm_pkg::CHAN_W + 1)'(item.channel) +
						(ltsm_pkg::CHAN_W + 1)'(ltsm_pkg::MOTOR_COUNT));
				end
			end
			ltsm_pkg::KIND_MOTOR_SAMPLE: begin
				if (motor_ok) begin
					cmd.op = ltsm_pkg::OP_SAMPLE;
				end
			end
			ltsm_pkg::KIND_CHECK: begin
				cmd.op = ltsm_pkg::OP_CHECK;
			end
			default: begin
				cmd.op = ltsm_pkg::OP_NONE;
			end
		endcase
	end

endmodule

@@ sv/ltsm_queue.sv @@
// ----------------------------------------------------------------------------
// Link timeout and stall monitor, command queue
// Short first-in first-out buffer of decoded commands between the front end
// and the executor.
// ----------------------------------------------------------------------------
module ltsm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ltsm_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output ltsm_pkg::cmd_t rd_cmd,
	output logic           empty
);

	ltsm_pkg::cmd_t                slot_q [ltsm_pkg::QUEUE_DEPTH];
	logic [ltsm_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [ltsm_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [ltsm_pkg::QCNT_W-1:0]   count_q;

	assign full   = count_q == ltsm_pkg::QCNT_W'(ltsm_pkg::QUEUE_DEPTH);
	assign empty  = count_q == '0;
	assign rd_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ltsm_pkg::QPTR_W'(ltsm_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == ltsm_pkg::QPTR_W'(ltsm_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("Queue written while full.");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("Queue read while empty.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("Queue count did not follow a write.");

endmodule

@@ sv/ltsm_back.sv @@
// ----------------------------------------------------------------------------
// Link timeout and stall monitor, executor
// Keeps time, contact stamps and stall timers, walks all channels on a check
// and holds the result register toward the output channel.
// ----------------------------------------------------------------------------
module ltsm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ltsm_pkg::cfg_t       cfg,
	input  logic                 q_empty,
	input  ltsm_pkg::cmd_t       q_cmd,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output ltsm_pkg::out_item_t  result
);

	typedef enum logic {
		ST_RUN,
		ST_WALK
	} state_t;

	state_t                              state_q;
	logic [ltsm_pkg::TIME_W-1:0]         now_q;
	logic [ltsm_pkg::TIME_W-1:0]         heard_q [ltsm_pkg::CH_COUNT];
	logic [ltsm_pkg::TIME_W-1:0]         began_q [ltsm_pkg::MOTOR_COUNT];
	logic [ltsm_pkg::MOTOR_COUNT-1:0]    timing_q;
	logic [ltsm_pkg::STALL_SPAN-1:0]     stall_q;
	logic [ltsm_pkg::OFF_SPAN-1:0]       offline_q;
	logic [ltsm_pkg::OFF_SPAN-1:0]       acc_q;
	logic [ltsm_pkg::CH_IDX_W-1:0]       walk_q;
	logic                                out_valid_q;
	ltsm_pkg::out_item_t                 out_q;

	logic                                out_free;
	logic                                out_load;
	logic [ltsm_pkg::MOT_IDX_W-1:0]      mot;
	logic                                stall_hit;
	logic [ltsm_pkg::STALL_SPAN-1:0]     stall_next;
	logic [ltsm_pkg::TIME_W-1:0]         timeout;
	logic                                walk_hit;
	logic [ltsm_pkg::OFF_SPAN-1:0]       acc_next;
	logic                                walk_last;

	assign out_free     = !out_valid_q || !result_stall;
	assign pop          = (state_q == ST_RUN) && !q_empty && out_free;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign mot       = q_cmd.idx[ltsm_pkg::MOT_IDX_W-1:0];
	assign stall_hit = q_cmd.cond && timing_q[mot] &&
		((now_q - began_q[mot]) > cfg.stall_time);

	always_comb begin
		stall_next = stall_q;
		if (pop && q_cmd.op == ltsm_pkg::OP_SAMPLE) begin
			stall_next[mot] = stall_hit;
		end
	end

	assign timeout  = (walk_q < ltsm_pkg::CH_IDX_W'(ltsm_pkg::MOTOR_COUNT)) ?
		cfg.motor_timeout : cfg.device_timeout;
	assign walk_hit  = (now_q - heard_q[walk_q]) > timeout;
	assign walk_last = walk_q == ltsm_pkg::CH_IDX_W'(ltsm_pkg::CH_COUNT - 1);

	assign out_load = (pop && q_cmd.op != ltsm_pkg::OP_CHECK) ||
		((state_q == ST_WALK) && walk_last && out_free);

	always_comb begin
		acc_next = acc_q;
		acc_next[walk_q] = walk_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			now_q       <= '0;
			heard_q     <= '{default: '0};
			began_q     <= '{default: '0};
			timing_q    <= '0;
			stall_q     <= '0;
			offline_q   <= '0;
			acc_q       <= '0;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (pop) begin
						case (q_cmd.op)
							ltsm_pkg::OP_TICK: begin
								now_q <= now_q + 1'b1;
							end
							ltsm_pkg::OP_MOTOR_HEARD, ltsm_pkg::OP_DEVICE_HEARD: begin
								heard_q[q_cmd.idx] <= now_q;
							end
							ltsm_pkg::OP_SAMPLE: begin
								if (q_cmd.cond) begin
									if (!timing_q[mot]) begin
										timing_q[mot] <= 1'b1;
										began_q[mot]  <= now_q;
									end
								end else begin
									timing_q[mot] <= 1'b0;
								end
								stall_q <= stall_next;
							end
							ltsm_pkg::OP_CHECK: begin
								state_q <= ST_WALK;
								walk_q  <= '0;
								acc_q   <= '0;
							end
							default: begin
							end
						endcase
						if (q_cmd.op != ltsm_pkg::OP_CHECK) begin
							out_q.offline_flags <= offline_q[ltsm_pkg::OFF_W-1:0];
							out_q.stall_flags   <= stall_next[ltsm_pkg::STALL_W-1:0];
							out_q.any_stall     <= |stall_next;
						end
					end
				end
				ST_WALK: begin
					if (!walk_last) begin
						acc_q  <= acc_next;
						walk_q <= walk_q + 1'b1;
					end else if (out_free) begin
						offline_q           <= acc_next;
						state_q             <= ST_RUN;
						out_q.offline_flags <= acc_next[ltsm_pkg::OFF_W-1:0];
						out_q.stall_flags   <= stall_q[ltsm_pkg::STALL_W-1:0];
						out_q.any_stall     <= |stall_q;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(stall_q[ltsm_pkg::MOTOR_COUNT-1:0] & ~timing_q) == '0)
		else $error("Stall flag set without a running stall timer.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_cmd.op == ltsm_pkg::OP_CHECK) |=> (state_q == ST_WALK && walk_q == '0))
		else $error("Check command did not start a channel walk.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (walk_q < ltsm_pkg::CH_IDX_W'(ltsm_pkg::CH_COUNT)))
		else $error("Channel walk ran past the last channel.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !pop)
		else $error("Command taken during a channel walk.");

endmodule
